// ===== hw/rtl/stack_machine_alu_core_defines.svh =====
// Assertion macros used by sma_checker, the checker file of stack_machine_alu_core.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while rst_n is low.
`ifndef STACK_MACHINE_ALU_CORE_DEFINES_SVH
`define STACK_MACHINE_ALU_CORE_DEFINES_SVH

// Same-cycle implication.
`define SMA_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack_machine_alu_core: assertion failed");

// Next-cycle implication.
`define SMA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack_machine_alu_core: assertion failed");

`endif

// ===== hw/rtl/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg
// Opcodes, status codes and controller/datapath interface types of the
// stack machine ALU.
// ----------------------------------------------------------------------------
package sma_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_POP  = 3'd1;
    localparam logic [2:0] OP_ADD  = 3'd2;
    localparam logic [2:0] OP_SUB  = 3'd3;
    localparam logic [2:0] OP_MUL  = 3'd4;
    localparam logic [2:0] OP_OUT  = 3'd5;
    localparam logic [2:0] OP_HALT = 3'd6;
    localparam logic [2:0] OP_NOP  = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_HALT  = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;    // capture the instruction beat, start stack read
        logic commit;  // update stack state and load the result register
    } sma_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_full;  // result register holds a beat not yet taken
    } sma_sts_t;

endpackage

// ===== hw/rtl/sma_ctrl.sv =====
// ----------------------------------------------------------------------------
// sma_ctrl
// Two-state sequencer: accept an instruction, then execute it once the
// result register can take the outcome.
// ----------------------------------------------------------------------------
module sma_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    input  sma_pkg::sma_sts_t sts,
    output sma_pkg::sma_cmd_t cmd
);
    import sma_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic slot_free;

    assign slot_free  = !sts.out_full || out_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.commit = (state_reg == S_EXEC) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the result register frees up
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/sma_dpath.sv =====
// ----------------------------------------------------------------------------
// sma_dpath
// Operand stack (top word in a register, the rest in a memory), ALU,
// halt flag and the result register.
// ----------------------------------------------------------------------------
module sma_dpath #(
    parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sma_pkg::sma_cmd_t  cmd,
    output sma_pkg::sma_sts_t  sts,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               value_valid,
    output logic signed [31:0] result_value
);
    import sma_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [31:0]   mem [STACK_DEPTH];

    logic [2:0]    op_reg;
    logic [31:0]   pv_reg;
    logic [31:0]   top_reg;
    logic [31:0]   top_next;
    logic [31:0]   second_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          halted_reg;
    logic          halted_next;

    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic          vv_reg;
    logic [31:0]   value_reg;

    logic [1:0]    st_c;
    logic          vv_c;
    logic [31:0]   val_c;
    logic          wr_en;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [31:0]   alu_r;

    assign cnt_m1  = cnt_reg - CW'(1);
    assign cnt_m2  = cnt_reg - CW'(2);
    assign wr_addr = cnt_m1[AW-1:0];
    assign rd_addr = cnt_m2[AW-1:0];

    // Second word of the stack, read as the instruction is captured.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= req_type;
            pv_reg     <= push_value;
            second_reg <= mem[rd_addr];
        end
        if (cmd.commit && wr_en)
        begin
            mem[wr_addr] <= top_reg;
        end
    end

    always_comb
    begin
        case (op_reg)
            OP_ADD:  alu_r = second_reg + top_reg;
            OP_SUB:  alu_r = second_reg - top_reg;
            default: alu_r = second_reg * top_reg;
        endcase
    end

    always_comb
    begin
        st_c        = ST_OK;
        vv_c        = 1'b0;
        val_c       = '0;
        top_next    = top_reg;
        cnt_next    = cnt_reg;
        halted_next = halted_reg;
        wr_en       = 1'b0;
        if (halted_reg)
        begin
            st_c = ST_HALT;
        end
        else
        begin
            unique case (op_reg) inside
                OP_PUSH:
                begin
                    if (cnt_reg == CW'(STACK_DEPTH))
                    begin
                        st_c = ST_OVER;
                    end
                    else
                    begin
                        // spill the old top word below the new one
                        wr_en    = (cnt_reg != '0);
                        top_next = pv_reg;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                OP_POP:
                begin
                    if (cnt_reg == '0)
                    begin
                        st_c = ST_UNDER;
                    end
                    else
                    begin
                        top_next = second_reg;
                        cnt_next = cnt_m1;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        st_c = ST_UNDER;
                    end
                    else if (cnt_reg == CW'(1))
                    begin
                        // lone operand stays consumed
                        st_c     = ST_UNDER;
                        cnt_next = '0;
                    end
                    else
                    begin
                        top_next = alu_r;
                        cnt_next = cnt_m1;
                        vv_c     = 1'b1;
                        val_c    = alu_r;
                    end
                end
                OP_OUT:
                begin
                    if (cnt_reg == '0)
                    begin
                        st_c = ST_UNDER;
                    end
                    else
                    begin
                        vv_c  = 1'b1;
                        val_c = top_reg;
                    end
                end
                OP_HALT:
                begin
                    halted_next = 1'b1;
                    st_c        = ST_HALT;
                end
                default:
                begin
                    st_c = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                cnt_reg       <= cnt_next;
                halted_reg    <= halted_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            top_reg    <= top_next;
            status_reg <= st_c;
            vv_reg     <= vv_c;
            value_reg  <= val_c;
        end
    end

    assign sts.out_full = out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign value_valid  = vv_reg;
    assign result_value = value_reg;

endmodule

// ===== hw/rtl/stack_machine_alu_core.sv =====
// ----------------------------------------------------------------------------
// stack_machine_alu_core
// Stack machine calculator: one instruction beat in, one result beat out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_ready  | req_type, push_value
//  out     | output    | out_valid / out_ready| status, value_valid, result_value
//
// Each instruction is first captured, which takes the beat and reads the
// second stack word from the stack memory, and then executed against the
// registered top word. The stack memory's single registered read port is why
// the read comes first. A held result beat stalls execution of the next
// instruction, which may still be captured meanwhile. After reset the stack
// is empty and the block is ready at once.
// ----------------------------------------------------------------------------
module stack_machine_alu_core #(
    parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               value_valid,
    output logic signed [31:0] result_value
);
    import sma_pkg::*;

    sma_cmd_t cmd;
    sma_sts_t sts;

    sma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sma_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value_valid  (value_valid),
        .result_value (result_value)
    );

endmodule

// ===== hw/rtl/sma_checker.sv =====
// ----------------------------------------------------------------------------
// sma_checker
// Port-level checks on the result channel of stack_machine_alu_core.
// ----------------------------------------------------------------------------
`include "stack_machine_alu_core_defines.svh"

module sma_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic               value_valid,
    input logic signed [31:0] result_value
);
    import sma_pkg::*;

    logic seen_halt_reg;

    // remember a delivered halted beat; only reset clears it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
        end
        else if (out_valid && out_ready && status == ST_HALT)
        begin
            seen_halt_reg <= 1'b1;
        end
    end

    `SMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(value_valid) && $stable(result_value))
    `SMA_ASSERT_IMPLY(a_value_zero, out_valid && !value_valid, result_value == 32'sd0)
    `SMA_ASSERT_IMPLY(a_value_ok, out_valid && value_valid, status == ST_OK)
    `SMA_ASSERT_IMPLY(a_halt_sticky, out_valid && seen_halt_reg, status == ST_HALT && !value_valid)

endmodule

bind stack_machine_alu_core sma_checker u_sma_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .value_valid  (value_valid),
    .result_value (result_value)
);

// ===== tb/sv/stack_calc_checker.sv =====
// ----------------------------------------------------------------------------
// stack_calc_checker
// Watches the instruction and result channels of stack_machine_alu_core. It
// keeps its own operand stack, count and halt flag, works out the result
// beat of every accepted instruction, and compares each result beat with
// the oldest one still awaited.
// ----------------------------------------------------------------------------
module stack_calc_checker #(
    parameter int DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] push_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         status,
    input  logic               value_valid,
    input  logic signed [31:0] result_value,
    output int                 mismatch_count,
    output int                 pending_count,
    output int                 checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import sma_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        value_valid;
        logic [31:0] value;
    } calc_result_t;

    logic [31:0]  stack_words [DEPTH];
    int unsigned  words_held;
    bit           halted;
    calc_result_t awaited_results [$];

    // Run one instruction against the shadow stack and return its result beat.
    function automatic calc_result_t execute_instr(input logic [2:0] op,
                                                   input logic [31:0] operand);
        calc_result_t res;
        logic [31:0]  top_word;
        logic [31:0]  next_word;
        res = '0;
        res.status = ST_OK;
        if (halted)
        begin
            res.status = ST_HALT;
            return res;
        end
        case (op)
            OP_PUSH:
            begin
                if (words_held >= DEPTH)
                    res.status = ST_OVER;
                else
                begin
                    stack_words[words_held] = operand;
                    words_held++;
                end
            end
            OP_POP:
            begin
                if (words_held == 0)
                    res.status = ST_UNDER;
                else
                    words_held--;
            end
            OP_ADD, OP_SUB, OP_MUL:
            begin
                if (words_held == 0)
                    res.status = ST_UNDER;
                else
                begin
                    // the top word is consumed even if the second pop fails
                    words_held--;
                    top_word = stack_words[words_held];
                    if (words_held == 0)
                        res.status = ST_UNDER;
                    else
                    begin
                        next_word = stack_words[words_held - 1];
                        if (op == OP_ADD)
                            res.value = next_word + top_word;
                        else if (op == OP_SUB)
                            res.value = next_word - top_word;
                        else
                            res.value = next_word * top_word;
                        stack_words[words_held - 1] = res.value;
                        res.value_valid = 1'b1;
                    end
                end
            end
            OP_OUT:
            begin
                if (words_held == 0)
                    res.status = ST_UNDER;
                else
                begin
                    res.value = stack_words[words_held - 1];
                    res.value_valid = 1'b1;
                end
            end
            OP_HALT:
            begin
                halted = 1'b1;
                res.status = ST_HALT;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        calc_result_t awaited;
        if (!rst_n)
        begin
            words_held = 0;
            halted = 1'b0;
            awaited_results.delete();
            mismatch_count <= 0;
            pending_count <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                awaited_results.push_back(execute_instr(req_type, push_value));
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result beat with none awaited: expected nothing, got status=%0d valid=%0b value=%0d",
                             $time, status, value_valid, result_value);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    awaited = awaited_results.pop_front();
                    checked_count <= checked_count + 1;
                    if (status !== awaited.status || value_valid !== awaited.value_valid ||
                        result_value !== $signed(awaited.value))
                    begin
                        $display("%0t: result beat %0d: expected status=%0d valid=%0b value=%0d, got status=%0d valid=%0b value=%0d",
                                 $time, checked_count, awaited.status, awaited.value_valid,
                                 $signed(awaited.value), status, value_valid, result_value);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            pending_count <= awaited_results.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives instruction beats into stack_machine_alu_core: a directed run over
// the empty-stack, one-word and wrapping cases, then random expressions,
// fill-and-drain bursts and noise under four pacing modes, and a halt at the
// end. The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sma_pkg::*;

    localparam int DEPTH          = STACK_DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int PHASES         = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_GAP        = 40;

    typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         req_type;
    logic signed [31:0] push_value;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic               value_valid;
    logic signed [31:0] result_value;

    int    mismatch_count;
    int    pending_count;
    int    checked_count;
    int    idle_cycles;
    int    instr_sent;
    int    op_count [8];
    pace_t pace_mode;

    stack_machine_alu_core #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .push_value(push_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .value_valid(value_valid),
        .result_value(result_value)
    );

    stack_calc_checker #(
        .DEPTH(DEPTH)
    ) calc_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .push_value(push_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .value_valid(value_valid),
        .result_value(result_value),
        .mismatch_count(mismatch_count),
        .pending_count(pending_count),
        .checked_count(checked_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Result side: stall at the rate the current pacing mode asks.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            case (pace_mode)
                PACE_RECV_STALL: out_ready <= ($urandom_range(99) >= 85);
                PACE_BOTH:       out_ready <= ($urandom_range(99) >= 18);
                default:         out_ready <= 1'b1;
            endcase
        end
    end

    // End the run if neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hffff_ffff;
            3:       return 32'h8000_0000;
            4:       return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_arith_op();
        case ($urandom_range(2))
            0:       return OP_ADD;
            1:       return OP_SUB;
            default: return OP_MUL;
        endcase
    endfunction

    // Present one instruction beat and hold it until accepted.
    task automatic issue_instr(input logic [2:0] op, input logic [31:0] operand);
        int gap;
        int idle_pct;
        gap = 0;
        idle_pct = (pace_mode == PACE_SEND_IDLE) ? 85 : (pace_mode == PACE_BOTH) ? 18 : 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        push_value <= operand;
        do
            @(posedge clk);
        while (!in_ready);
        op_count[op]++;
        instr_sent++;
    endtask

    // Push a few words and fold them with arithmetic, sometimes one op too many.
    task automatic run_expression();
        int words;
        int folds;
        words = $urandom_range(1, 5);
        folds = words - 1 + (($urandom_range(9) == 0) ? 1 : 0);
        repeat (words) issue_instr(OP_PUSH, pick_operand());
        repeat (folds)
        begin
            if ($urandom_range(3) == 0)
                issue_instr(OP_OUT, pick_operand());
            issue_instr(pick_arith_op(), pick_operand());
        end
        issue_instr(OP_OUT, pick_operand());
        if ($urandom_range(1) == 1)
            issue_instr(OP_POP, pick_operand());
    endtask

    // Fill past the top, then reduce past the bottom.
    task automatic run_fill_drain();
        repeat (DEPTH + 2) issue_instr(OP_PUSH, pick_operand());
        issue_instr(OP_OUT, pick_operand());
        repeat (DEPTH + 2)
        begin
            if ($urandom_range(3) == 0)
                issue_instr(OP_POP, pick_operand());
            else
                issue_instr(pick_arith_op(), pick_operand());
        end
    endtask

    task automatic run_noise();
        logic [2:0] op;
        repeat ($urandom_range(1, 6))
        begin
            op = 3'($urandom_range(7));
            // keep halt for the very end
            if (op == OP_HALT)
                op = OP_NOP;
            issue_instr(op, pick_operand());
        end
    endtask

    initial
    begin : stimulus
        int directed_sent;
        int choice;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        req_type <= OP_NOP;
        push_value <= '0;
        instr_sent = 0;
        foreach (op_count[i])
            op_count[i] = 0;
        pace_mode = PACE_FULL;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty stack: pop, out and a binary op all underflow
        issue_instr(OP_POP, 32'h8000_0000);
        issue_instr(OP_OUT, 32'h7fff_ffff);
        issue_instr(OP_ADD, 32'hffff_ffff);
        // one word: sub consumes it and underflows, out then sees empty
        issue_instr(OP_PUSH, 32'h7fff_ffff);
        issue_instr(OP_SUB, 32'h0000_0000);
        issue_instr(OP_OUT, 32'h0000_0000);
        issue_instr(OP_MUL, 32'h0000_0001);
        // wrapping add, sub and mul at the extremes
        issue_instr(OP_PUSH, 32'h7fff_ffff);
        issue_instr(OP_PUSH, 32'h0000_0001);
        issue_instr(OP_ADD, 32'h0000_0000);
        issue_instr(OP_PUSH, 32'h0000_0001);
        issue_instr(OP_SUB, 32'h0000_0000);
        issue_instr(OP_PUSH, 32'hffff_ffff);
        issue_instr(OP_MUL, 32'h0000_0000);
        issue_instr(OP_PUSH, 32'h8000_0000);
        issue_instr(OP_PUSH, 32'h8000_0000);
        issue_instr(OP_MUL, 32'h0000_0000);
        issue_instr(OP_PUSH, 32'h0000_0000);
        issue_instr(OP_SUB, 32'h0000_0000);
        issue_instr(OP_OUT, 32'hffff_ffff);
        // no-op leaves the stack alone
        issue_instr(OP_NOP, 32'hffff_ffff);
        issue_instr(OP_OUT, 32'h0000_0000);
        issue_instr(OP_POP, 32'h0000_0000);
        issue_instr(OP_POP, 32'h0000_0000);
        issue_instr(OP_POP, 32'h0000_0000);
        directed_sent = instr_sent;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            pace_mode = pace_t'(phase % 4);
            while (instr_sent < directed_sent + (phase + 1) * RANDOM_ITEMS / PHASES)
            begin
                choice = $urandom_range(99);
                if (choice < 8)
                    run_fill_drain();
                else if (choice < 75)
                    run_expression();
                else
                    run_noise();
            end
        end

        // halt, then every opcode must report halted
        pace_mode = PACE_BOTH;
        issue_instr(OP_HALT, pick_operand());
        for (int op = 0; op < 8; op++)
            issue_instr(3'(op), pick_operand());
        issue_instr(OP_PUSH, 32'h7fff_ffff);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Drove %0d instructions: push %0d, pop %0d, add %0d, sub %0d, mul %0d, out %0d, halt %0d, nop %0d.",
                 instr_sent, op_count[OP_PUSH], op_count[OP_POP], op_count[OP_ADD],
                 op_count[OP_SUB], op_count[OP_MUL], op_count[OP_OUT], op_count[OP_HALT],
                 op_count[OP_NOP]);
        $display("Compared %0d result beats over full, empty and halted stacks in four pacing modes.",
                 checked_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== stack_machine_alu_core.f =====
+incdir+hw/rtl
hw/rtl/sma_pkg.sv
hw/rtl/sma_ctrl.sv
hw/rtl/sma_dpath.sv
hw/rtl/stack_machine_alu_core.sv
hw/rtl/sma_checker.sv
tb/sv/stack_calc_checker.sv
tb/sv/testbench.sv
